/* src/alb_pkg.sv */
// ----------------------------------------------------------------------------
// alb_pkg: shared types and constants of the adjacency list builder
// Sizes of the vertex table and neighbor lists, field widths, operation and
// status codes, and the structs that pass between the sequencer and the top.
// ----------------------------------------------------------------------------
package alb_pkg;

  // Table capacity
  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_DEGREE   = 64;

  // Fixed field widths of the item ports
  localparam int unsigned LABEL_W  = 8;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DEG_O_W  = 7;
  localparam int unsigned TOTAL_W  = 7;

  // Internal widths derived from the capacity
  localparam int unsigned VW   = $clog2(MAX_VERTICES);   // vertex slot address
  localparam int unsigned DW   = $clog2(MAX_DEGREE);     // list position address
  localparam int unsigned CW   = $clog2(MAX_VERTICES + 1); // vertex count
  localparam int unsigned DGW  = $clog2(MAX_DEGREE + 1);   // degree
  localparam int unsigned IW   = (CW > DGW) ? CW : DGW;    // scan index
  localparam int unsigned NAW  = VW + DW;                  // neighbor store address
  localparam int unsigned NDEPTH = MAX_VERTICES * MAX_DEGREE;
  // Range compares: wide enough for the port fields and the counts
  localparam int unsigned RNG_W = 9;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // One vertex table entry: label and number of stored neighbors
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [DGW-1:0]     degree;
  } vent_t;

  // Vertex table access for one cycle
  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    vent_t         wdata;
    logic [VW-1:0] raddr;
  } vmem_req_t;

  // Neighbor store access for one cycle
  typedef struct packed {
    logic               we;
    logic [NAW-1:0]     waddr;
    logic [LABEL_W-1:0] wdata;
    logic [NAW-1:0]     raddr;
  } nmem_req_t;

  // One result item
  typedef struct packed {
    status_t            status;
    logic [LABEL_W-1:0] vertex_label;
    logic [LABEL_W-1:0] neighbor_label;
    logic [DEG_O_W-1:0] degree;
    logic [TOTAL_W-1:0] vertex_total;
  } res_t;

endpackage

/* src/alb_ram.sv */
// ----------------------------------------------------------------------------
// alb_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and appears in the cycle after the read address.
// ----------------------------------------------------------------------------
module alb_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/alb_seq.sv */
// ----------------------------------------------------------------------------
// alb_seq: insert and read sequencer
// Scans the vertex table and one neighbor list per edge direction with one
// read a cycle, then appends through read-modify-write of the table entry.
// ----------------------------------------------------------------------------
module alb_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [alb_pkg::LABEL_W-1:0] in_a,
  input  logic [alb_pkg::LABEL_W-1:0] in_b,
  input  logic [alb_pkg::SLOT_W-1:0]  in_slot,
  input  logic [alb_pkg::POS_W-1:0]   in_pos,
  output alb_pkg::vmem_req_t          vreq,
  input  alb_pkg::vent_t              vm_rdata,
  output alb_pkg::nmem_req_t          nreq,
  input  logic [alb_pkg::LABEL_W-1:0] nm_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output alb_pkg::res_t               res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VSCAN,
    S_NSCAN,
    S_RDWAIT,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         dir_r, dir_nxt;
  logic [alb_pkg::LABEL_W-1:0]  a_r, a_nxt;
  logic [alb_pkg::LABEL_W-1:0]  b_r, b_nxt;
  logic                         drop_r, drop_nxt;
  logic [alb_pkg::IW-1:0]       idx_r, idx_nxt;
  logic [alb_pkg::IW-1:0]       pidx_r, pidx_nxt;
  logic                         pend_r, pend_nxt;
  logic [alb_pkg::VW-1:0]       slot_r, slot_nxt;
  logic [alb_pkg::DGW-1:0]      deg_r, deg_nxt;
  logic [alb_pkg::CW-1:0]       count_r, count_nxt;
  logic [alb_pkg::SLOT_W-1:0]   rd_slot_r, rd_slot_nxt;
  logic [alb_pkg::POS_W-1:0]    rd_pos_r, rd_pos_nxt;
  alb_pkg::res_t                res_r, res_nxt;

  // Next-state logic and memory requests.
  always_comb begin
    logic [alb_pkg::LABEL_W-1:0] src;
    logic [alb_pkg::LABEL_W-1:0] dst;
    logic                        dir_end;
    logic                        drop_now;

    state_nxt   = state_r;
    dir_nxt     = dir_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    drop_nxt    = drop_r;
    idx_nxt     = idx_r;
    pidx_nxt    = pidx_r;
    pend_nxt    = pend_r;
    slot_nxt    = slot_r;
    deg_nxt     = deg_r;
    count_nxt   = count_r;
    rd_slot_nxt = rd_slot_r;
    rd_pos_nxt  = rd_pos_r;
    res_nxt     = res_r;
    vreq        = '0;
    nreq        = '0;
    dir_end     = 1'b0;
    drop_now    = 1'b0;

    // The second direction swaps the endpoints.
    src = dir_r ? b_r : a_r;
    dst = dir_r ? a_r : b_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == alb_pkg::OP_READ) begin
            // Both memories are read at once; range checks follow.
            vreq.raddr  = alb_pkg::VW'(in_slot);
            nreq.raddr  = {alb_pkg::VW'(in_slot), alb_pkg::DW'(in_pos)};
            rd_slot_nxt = in_slot;
            rd_pos_nxt  = in_pos;
            state_nxt   = S_RDWAIT;
          end else begin
            a_nxt     = in_a;
            b_nxt     = in_b;
            dir_nxt   = 1'b0;
            drop_nxt  = 1'b0;
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_VSCAN;
          end
        end
      end

      S_VSCAN: begin
        // Look up the source label, one slot per cycle.
        if (pend_r && (vm_rdata.label == src)) begin
          slot_nxt  = pidx_r[alb_pkg::VW-1:0];
          deg_nxt   = vm_rdata.degree;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_NSCAN;
        end else if (idx_r < alb_pkg::IW'(count_r)) begin
          vreq.raddr = idx_r[alb_pkg::VW-1:0];
          pend_nxt   = 1'b1;
          pidx_nxt   = idx_r;
          idx_nxt    = idx_r + 1'b1;
        end else begin
          // New vertex: take the next slot with the partner as first neighbor, or drop if the table is full.
          if (count_r == alb_pkg::CW'(alb_pkg::MAX_VERTICES)) begin
            drop_now = 1'b1;
          end else begin
            vreq.we           = 1'b1;
            vreq.waddr        = count_r[alb_pkg::VW-1:0];
            vreq.wdata.label  = src;
            vreq.wdata.degree = alb_pkg::DGW'(1);
            nreq.we           = 1'b1;
            nreq.waddr        = {count_r[alb_pkg::VW-1:0], alb_pkg::DW'(0)};
            nreq.wdata        = dst;
            count_nxt         = count_r + 1'b1;
          end
          dir_end = 1'b1;
        end
      end

      S_NSCAN: begin
        // Search the slot's list for the partner.
        if (pend_r && (nm_rdata == dst)) begin
          dir_end = 1'b1;
        end else if (idx_r < alb_pkg::IW'(deg_r)) begin
          nreq.raddr = {slot_r, idx_r[alb_pkg::DW-1:0]};
          pend_nxt   = 1'b1;
          pidx_nxt   = idx_r;
          idx_nxt    = idx_r + 1'b1;
        end else begin
          // Partner is new to the list: append it and bump the degree, or drop if the list is full.
          if (deg_r == alb_pkg::DGW'(alb_pkg::MAX_DEGREE)) begin
            drop_now = 1'b1;
          end else begin
            nreq.we           = 1'b1;
            nreq.waddr        = {slot_r, deg_r[alb_pkg::DW-1:0]};
            nreq.wdata        = dst;
            vreq.we           = 1'b1;
            vreq.waddr        = slot_r;
            vreq.wdata.label  = src;
            vreq.wdata.degree = deg_r + 1'b1;
          end
          dir_end = 1'b1;
        end
      end

      S_RDWAIT: begin
        // Memory data is back; apply the slot and position range checks.
        res_nxt.vertex_label   = '0;
        res_nxt.neighbor_label = '0;
        res_nxt.degree         = '0;
        res_nxt.vertex_total   = '0;
        if (alb_pkg::RNG_W'(rd_slot_r) >= alb_pkg::RNG_W'(count_r)) begin
          res_nxt.status = alb_pkg::ST_RANGE;
        end else begin
          res_nxt.vertex_label = vm_rdata.label;
          res_nxt.degree       = alb_pkg::DEG_O_W'(vm_rdata.degree);
          if (alb_pkg::RNG_W'(rd_pos_r) >= alb_pkg::RNG_W'(vm_rdata.degree)) begin
            res_nxt.status = alb_pkg::ST_RANGE;
          end else begin
            res_nxt.status         = alb_pkg::ST_OK;
            res_nxt.neighbor_label = nm_rdata;
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // End of one direction: start the second one or close the insert.
    if (dir_end) begin
      drop_nxt = drop_r | drop_now;
      idx_nxt  = '0;
      pend_nxt = 1'b0;
      if (!dir_r) begin
        dir_nxt   = 1'b1;
        state_nxt = S_VSCAN;
      end else begin
        res_nxt.status         = (drop_r | drop_now) ? alb_pkg::ST_DROP : alb_pkg::ST_OK;
        res_nxt.vertex_label   = '0;
        res_nxt.neighbor_label = '0;
        res_nxt.degree         = '0;
        res_nxt.vertex_total   = '0;
        state_nxt              = S_DONE;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      dir_r   <= 1'b0;
      drop_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      dir_r   <= dir_nxt;
      drop_r  <= drop_nxt;
      idx_r   <= idx_nxt;
    end
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    pidx_r    <= pidx_nxt;
    slot_r    <= slot_nxt;
    deg_r     <= deg_nxt;
    rd_slot_r <= rd_slot_nxt;
    rd_pos_r  <= rd_pos_nxt;
    res_r     <= res_nxt;
  end

  // Handshake and result; the vertex total is the count at delivery.
  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res              = res_r;
    res.vertex_total = alb_pkg::TOTAL_W'(count_r);
  end

`ifndef SYNTH
  // The vertex count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= alb_pkg::CW'(alb_pkg::MAX_VERTICES))
    else $error("vertex count beyond table size");

  // The vertex count only ever grows by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r)))
      |-> (count_r == $past(count_r) + 1'b1))
    else $error("vertex count changed by more than one");

  // Every table write goes with a neighbor store write.
  a_write_pair: assert property (@(posedge clk) disable iff (!rst_n)
    vreq.we == nreq.we)
    else $error("vertex table and neighbor store writes out of step");

  // A scan read is only in flight while scanning.
  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((state_r == S_VSCAN) || (state_r == S_NSCAN)))
    else $error("scan read pending outside a scan");

  // A finished result waits until the output register takes it.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_r)))
    else $error("result lost before it was taken");
`endif

endmodule

/* src/adjacency_list_builder_top.sv */
// ----------------------------------------------------------------------------
// adjacency_list_builder_top: undirected adjacency table builder
// Inserts edges between 8-bit vertex labels in both directions and reads back
// one slot's label, degree, one neighbor and the vertex total.
//
//   Channel   Ports                    Moves
//   in_       valid / stall + fields   one insert or read item
//   out_      valid / stall + fields   one result item per input item
//
// A read looks up both memories at once and then applies the range checks.
// An insert scans the vertex table and, for a known source, its neighbor list
// once per direction; both scans read one entry a cycle through the single
// read port of the vertex table and of the neighbor store.
// One item is in work at a time; a new one is taken once the result has moved
// into the output register. Reset is synchronous and clears the vertex count;
// the memories need no clearing because only stored entries are ever used.
// ----------------------------------------------------------------------------
module adjacency_list_builder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_first_vertex,
  input  logic [7:0] in_second_vertex,
  input  logic [5:0] in_slot_index,
  input  logic [5:0] in_neighbor_position,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_vertex_label,
  output logic [7:0] out_neighbor_label,
  output logic [6:0] out_degree,
  output logic [6:0] out_vertex_total
);

  alb_pkg::vmem_req_t          vreq;
  alb_pkg::nmem_req_t          nreq;
  logic [$bits(alb_pkg::vent_t)-1:0] vm_rdata_raw;
  logic [alb_pkg::LABEL_W-1:0] nm_rdata;
  logic                        res_valid;
  logic                        res_ready;
  alb_pkg::res_t               res;
  logic                        out_valid_r, out_valid_nxt;
  alb_pkg::res_t               out_r;

  // Sequencer.
  alb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_a      (in_first_vertex),
    .in_b      (in_second_vertex),
    .in_slot   (in_slot_index),
    .in_pos    (in_neighbor_position),
    .vreq      (vreq),
    .vm_rdata  (alb_pkg::vent_t'(vm_rdata_raw)),
    .nreq      (nreq),
    .nm_rdata  (nm_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Vertex table: label and degree per slot.
  alb_ram #(
    .DEPTH (alb_pkg::MAX_VERTICES),
    .WIDTH ($bits(alb_pkg::vent_t))
  ) u_vtab (
    .clk   (clk),
    .we    (vreq.we),
    .waddr (vreq.waddr),
    .wdata (vreq.wdata),
    .raddr (vreq.raddr),
    .rdata (vm_rdata_raw)
  );

  // Neighbor store: one row of MAX_DEGREE labels per slot.
  alb_ram #(
    .DEPTH (alb_pkg::NDEPTH),
    .WIDTH (alb_pkg::LABEL_W)
  ) u_nstore (
    .clk   (clk),
    .we    (nreq.we),
    .waddr (nreq.waddr),
    .wdata (nreq.wdata),
    .raddr (nreq.raddr),
    .rdata (nm_rdata)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_vertex_label   = out_r.vertex_label;
  assign out_neighbor_label = out_r.neighbor_label;
  assign out_degree         = out_r.degree;
  assign out_vertex_total   = out_r.vertex_total;

endmodule
